// ===== sv/crdc_pkg.sv =====
// Shared types, constants and helper functions of the pad hit decoder.
`default_nettype none

package crdc_pkg;

    // Default geometry
    localparam int PADS_PER_DETECTOR_DEF = 256;
    localparam int DETECTORS_DEF         = 2;

    // Field widths
    localparam int OPCODE_W   = 2;
    localparam int RAW_W      = 16;
    localparam int PAD_W      = 8;
    localparam int CHAN_W     = 6;
    localparam int CONN_W     = 2;
    localparam int SAMPLE_W   = 9;
    localparam int ENERGY_W   = 10;
    localparam int FRAC_W     = 4;
    localparam int PED_W      = 14;
    localparam int GAIN_W     = 16;
    localparam int CALE_W     = 16;
    localparam int HIT_W      = 12;
    localparam int SLIM_W     = 10;
    localparam int PCNT_W     = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // Raw word layout
    localparam int CTRL_BIT    = 15;
    localparam int CHAN_LSB    = 0;
    localparam int SAMPLE_LSB  = 6;
    localparam int ENERGY_LSB  = 0;
    localparam int CONN_LSB    = 10;

    // Gain is Q2.14: product is shifted down by this after rounding
    localparam int GAIN_FRAC_W = 14;

    // Pad sample counters are kept in rows of four pads
    localparam int ROW_LANES = 4;
    localparam int LANE_W    = $clog2(ROW_LANES);

    localparam logic [HIT_W-1:0]  PAD_HITS_MAX     = '1;
    localparam logic [SLIM_W-1:0] SAMPLE_LIMIT_RST = 10'd512;
    localparam logic [HIT_W-1:0]  HIT_LIMIT_RST    = 12'd4095;
    localparam logic [PCNT_W-1:0] PAD_COUNT_RST    = 9'd256;

    typedef enum logic [OPCODE_W-1:0] {
        OP_READOUT     = 2'd0,
        OP_CAL_LOAD    = 2'd1,
        OP_EVENT_START = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        ST_HIT          = 2'd0,
        ST_SAMPLE_RANGE = 2'd1,
        ST_HIT_LIMIT    = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SAMPLE_LIMIT = 2'd0,
        REG_HIT_LIMIT    = 2'd1,
        REG_PAD_COUNT    = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic                detector;
        logic [RAW_W-1:0]    raw_word;
        logic [PAD_W-1:0]    cal_pad;
        logic [PED_W-1:0]    cal_pedestal;
        logic [GAIN_W-1:0]   cal_gain;
    } in_item_t;

    typedef struct packed {
        status_t             status;
        logic [PAD_W-1:0]    pad_number;
        logic [SAMPLE_W-1:0] sample_number;
        logic [CALE_W-1:0]   cal_energy;
        logic [HIT_W-1:0]    hit_index;
        logic [HIT_W-1:0]    pad_hits;
        logic                pad_out_of_range;
    } res_item_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_req_t;

    // Fold a pad number into one detector's table (pads >= 64, so three steps suffice)
    function automatic logic [PAD_W-1:0] pad_wrap(input logic [PAD_W-1:0] pad,
                                                  input int pads);
        logic [PAD_W:0] v;
        v = {1'b0, pad};
        for (int i = 0; i < 3; i++) begin
            if (int'(v) >= pads) begin
                v = (PAD_W+1)'(int'(v) - pads);
            end
        end
        return v[PAD_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== sv/crdc_stream_if.sv =====
// Valid/ready channel carrying one payload struct per request.
`default_nettype none

interface crdc_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== sv/crdc_pad_hit_decoder.sv =====
// Top level of the pad hit decoder: word decode, calibration, counters, result register.
`default_nettype none

// Decodes readout words of up to two pad detectors. One request is taken every cycle
// while the result register drains. A control word latches channel and sample and
// gives no result; a calibration load writes the pedestal/gain memory; an event start
// clears the detector's hit count and pad counters at once (per-row valid flags, no
// clearing pass after reset). A data word gives one result: a first stage reads the
// calibration memory and the pad counter row, and a second stage does subtract, one
// 14x16 multiply, rounding and saturation into the result register. The pad counter
// read-modify-write is forwarded between neighboring words, so back-to-back words on
// the same pad keep the full rate. Calibration entries that were never loaded read as
// undefined.
module crdc_pad_hit_decoder #(
    parameter int PADS_PER_DETECTOR = crdc_pkg::PADS_PER_DETECTOR_DEF,
    parameter int DETECTORS         = crdc_pkg::DETECTORS_DEF
) (
    input wire logic        clk,
    input wire logic        rst_n,
    crdc_stream_if.sink     in,
    crdc_stream_if.source   res,
    crdc_stream_if.sink     cfg
);
    import crdc_pkg::*;

    localparam int TBL_DEPTH = DETECTORS * PADS_PER_DETECTOR;
    localparam int TBL_AW    = $clog2(TBL_DEPTH);
    localparam int RPD       = (PADS_PER_DETECTOR + ROW_LANES - 1) / ROW_LANES;
    localparam int ROW_AW    = $clog2(RPD);
    localparam int CNT_DEPTH = DETECTORS * RPD;
    localparam int CNT_AW    = $clog2(CNT_DEPTH);
    localparam int ROW_W     = ROW_LANES * HIT_W;
    localparam int CAL_W     = GAIN_W + PED_W;
    localparam int PROD_W    = PED_W + GAIN_W;
    localparam int QUO_W     = PROD_W + 1 - GAIN_FRAC_W;

    // Configuration registers
    logic [SLIM_W-1:0] sample_limit_reg;
    logic [HIT_W-1:0]  hit_limit_reg;
    logic [PCNT_W-1:0] pad_count_reg;

    // Decoder state
    logic [CHAN_W-1:0]   latched_chan_reg;
    logic [SAMPLE_W-1:0] latched_sample_reg;
    logic [HIT_W-1:0]    hit_count_reg [DETECTORS];
    logic [HIT_W-1:0]    hit_count_next [DETECTORS];
    logic                row_valid_reg [DETECTORS][RPD];
    logic                row_valid_next [DETECTORS][RPD];

    // Request decode
    logic                in_acc;
    logic                is_data;
    logic                is_ctrl;
    logic                is_cal;
    logic                is_start;
    logic                det;
    logic [RAW_W-1:0]    word;
    logic [PAD_W-1:0]    pad_num;
    logic [PAD_W-1:0]    data_pad_mod;
    logic [PAD_W-1:0]    cal_pad_mod;
    logic [TBL_AW-1:0]   tbl_base;
    logic [TBL_AW-1:0]   cal_raddr;
    logic [TBL_AW-1:0]   cal_waddr;
    logic [ROW_AW-1:0]   row_in_det;
    logic [CNT_AW-1:0]   cnt_raddr;
    logic                sample_bad;
    logic                limit_bad;
    status_t             in_status;

    // Stage one
    logic                s1_valid_reg;
    status_t             s1_status_reg;
    logic [PAD_W-1:0]    s1_pad_reg;
    logic [SAMPLE_W-1:0] s1_sample_reg;
    logic [ENERGY_W-1:0] s1_energy_reg;
    logic [HIT_W-1:0]    s1_hidx_reg;
    logic                s1_oor_reg;
    logic                s1_det_reg;
    logic [ROW_AW-1:0]   s1_row_reg;
    logic [CNT_AW-1:0]   s1_caddr_reg;
    logic [LANE_W-1:0]   s1_lane_reg;
    logic                s1_row_valid_reg;
    logic                fwd_valid_reg;
    logic [ROW_W-1:0]    fwd_row_reg;
    logic                s1_adv;
    logic                wb_en;

    // Memory read data
    logic [CAL_W-1:0]    cal_rdata;
    logic [ROW_W-1:0]    cnt_rdata;

    // Stage one datapath
    logic [ROW_W-1:0]    cur_row;
    logic [HIT_W-1:0]    cur_cnt;
    logic [HIT_W-1:0]    new_cnt;
    logic [ROW_W-1:0]    wb_row;
    logic [PED_W-1:0]    ped;
    logic [GAIN_W-1:0]   gain;
    logic [PED_W-1:0]    e16;
    logic                e_pos;
    logic [PED_W-1:0]    diff;
    logic [PROD_W-1:0]   prod;
    logic [PROD_W:0]     rnd;
    logic [QUO_W-1:0]    quo;
    logic [CALE_W-1:0]   energy_cal;

    // Result register
    logic                out_valid_reg;
    res_item_t           out_reg;

    // Decode the request
    assign in_acc   = in.valid && in.ready;
    assign word     = in.payload.raw_word;
    assign det      = (DETECTORS > 1) ? in.payload.detector : 1'b0;
    assign is_data  = in_acc && (in.payload.opcode == OP_READOUT) && !word[CTRL_BIT];
    assign is_ctrl  = in_acc && (in.payload.opcode == OP_READOUT) && word[CTRL_BIT];
    assign is_cal   = in_acc && (in.payload.opcode == OP_CAL_LOAD);
    assign is_start = in_acc && (in.payload.opcode == OP_EVENT_START);

    // Form pad and memory addresses
    assign pad_num      = {word[CONN_LSB +: CONN_W], latched_chan_reg};
    assign data_pad_mod = pad_wrap(pad_num, PADS_PER_DETECTOR);
    assign cal_pad_mod  = pad_wrap(in.payload.cal_pad, PADS_PER_DETECTOR);
    assign tbl_base     = det ? TBL_AW'(PADS_PER_DETECTOR) : '0;
    assign cal_raddr    = tbl_base + TBL_AW'(data_pad_mod);
    assign cal_waddr    = tbl_base + TBL_AW'(cal_pad_mod);
    assign row_in_det   = ROW_AW'(data_pad_mod >> LANE_W);
    assign cnt_raddr    = (det ? CNT_AW'(RPD) : CNT_AW'(0)) + CNT_AW'(row_in_det);

    // Drop checks, sample range first
    assign sample_bad = {1'b0, latched_sample_reg} >= sample_limit_reg;
    assign limit_bad  = hit_count_reg[det] >= hit_limit_reg;
    always_comb
    begin
        if (sample_bad)
        begin
            in_status = ST_SAMPLE_RANGE;
        end
        else if (limit_bad)
        begin
            in_status = ST_HIT_LIMIT;
        end
        else
        begin
            in_status = ST_HIT;
        end
    end

    // Pipeline flow
    assign s1_adv   = !out_valid_reg || res.ready;
    assign in.ready = !s1_valid_reg || s1_adv;
    assign wb_en    = s1_valid_reg && s1_adv && (s1_status_reg == ST_HIT);
    assign cfg.ready = 1'b1;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_limit_reg <= SAMPLE_LIMIT_RST;
            hit_limit_reg    <= HIT_LIMIT_RST;
            pad_count_reg    <= PAD_COUNT_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.payload.index)
                REG_SAMPLE_LIMIT: sample_limit_reg <= cfg.payload.data[SLIM_W-1:0];
                REG_HIT_LIMIT:    hit_limit_reg    <= cfg.payload.data[HIT_W-1:0];
                REG_PAD_COUNT:    pad_count_reg    <= cfg.payload.data[PCNT_W-1:0];
                default:          ;
            endcase
        end
    end

    // Latch channel and sample from control words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latched_chan_reg   <= '0;
            latched_sample_reg <= '0;
        end
        else if (is_ctrl)
        begin
            latched_chan_reg   <= word[CHAN_LSB +: CHAN_W];
            latched_sample_reg <= word[SAMPLE_LSB +: SAMPLE_W];
        end
    end

    // Advance or clear per-detector hit counts
    always_comb
    begin
        for (int d = 0; d < DETECTORS; d++)
        begin
            hit_count_next[d] = hit_count_reg[d];
            if (is_start && (det == 1'(d)))
            begin
                hit_count_next[d] = '0;
            end
            else if (is_data && (in_status == ST_HIT) && (det == 1'(d)))
            begin
                hit_count_next[d] = hit_count_reg[d] + HIT_W'(1);
            end
        end
    end

    // Drop row flags at event start, set them on counter writeback
    always_comb
    begin
        for (int d = 0; d < DETECTORS; d++)
        begin
            for (int r = 0; r < RPD; r++)
            begin
                row_valid_next[d][r] = row_valid_reg[d][r];
                if (is_start && (det == 1'(d)))
                begin
                    row_valid_next[d][r] = 1'b0;
                end
                else if (wb_en && (s1_det_reg == 1'(d)) && (s1_row_reg == ROW_AW'(r)))
                begin
                    row_valid_next[d][r] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int d = 0; d < DETECTORS; d++)
            begin
                hit_count_reg[d] <= '0;
                for (int r = 0; r < RPD; r++)
                begin
                    row_valid_reg[d][r] <= 1'b0;
                end
            end
        end
        else
        begin
            hit_count_reg <= hit_count_next;
            row_valid_reg <= row_valid_next;
        end
    end

    // Calibration memory: {gain, pedestal}
    crdc_ram #(
        .WIDTH (CAL_W),
        .DEPTH (TBL_DEPTH)
    ) u_cal_ram (
        .clk   (clk),
        .we    (is_cal),
        .waddr (cal_waddr),
        .wdata ({in.payload.cal_gain, in.payload.cal_pedestal}),
        .re    (is_data),
        .raddr (cal_raddr),
        .rdata (cal_rdata)
    );

    // Pad sample counters, four pads per row
    crdc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (CNT_DEPTH)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (wb_en),
        .waddr (s1_caddr_reg),
        .wdata (wb_row),
        .re    (is_data),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    // Stage one control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else if (in.ready)
        begin
            s1_valid_reg  <= is_data;
            fwd_valid_reg <= is_data && wb_en && (cnt_raddr == s1_caddr_reg);
        end
    end

    // Stage one payload; capture the row being written back for the next word
    always_ff @(posedge clk)
    begin
        if (is_data)
        begin
            s1_status_reg    <= in_status;
            s1_pad_reg       <= pad_num;
            s1_sample_reg    <= latched_sample_reg;
            s1_energy_reg    <= word[ENERGY_LSB +: ENERGY_W];
            s1_hidx_reg      <= hit_count_reg[det];
            s1_oor_reg       <= {1'b0, pad_num} >= pad_count_reg;
            s1_det_reg       <= det;
            s1_row_reg       <= row_in_det;
            s1_caddr_reg     <= cnt_raddr;
            s1_lane_reg      <= data_pad_mod[LANE_W-1:0];
            s1_row_valid_reg <= row_valid_reg[det][row_in_det];
            fwd_row_reg      <= wb_row;
        end
    end

    // Pick the current counter row: forwarded, stored, or cleared
    always_comb
    begin
        if (fwd_valid_reg)
        begin
            cur_row = fwd_row_reg;
        end
        else if (s1_row_valid_reg)
        begin
            cur_row = cnt_rdata;
        end
        else
        begin
            cur_row = '0;
        end
    end

    // Saturating increment of the pad's lane
    always_comb
    begin
        cur_cnt = '0;
        for (int l = 0; l < ROW_LANES; l++)
        begin
            if (s1_lane_reg == LANE_W'(l))
            begin
                cur_cnt = cur_row[l*HIT_W +: HIT_W];
            end
        end
        new_cnt = (cur_cnt == PAD_HITS_MAX) ? cur_cnt : cur_cnt + HIT_W'(1);
        for (int l = 0; l < ROW_LANES; l++)
        begin
            wb_row[l*HIT_W +: HIT_W] = (s1_lane_reg == LANE_W'(l)) ? new_cnt
                                                                   : cur_row[l*HIT_W +: HIT_W];
        end
    end

    // Subtract pedestal, scale by gain, round half up, saturate
    assign ped   = cal_rdata[PED_W-1:0];
    assign gain  = cal_rdata[CAL_W-1:PED_W];
    assign e16   = {s1_energy_reg, FRAC_W'(0)};
    assign e_pos = e16 > ped;
    assign diff  = e16 - ped;
    assign prod  = diff * gain;
    assign rnd   = {1'b0, prod} + (PROD_W+1)'(1 << (GAIN_FRAC_W - 1));
    assign quo   = rnd[PROD_W:GAIN_FRAC_W];
    always_comb
    begin
        if (!e_pos)
        begin
            energy_cal = '0;
        end
        else if (quo[QUO_W-1:CALE_W] != '0)
        begin
            energy_cal = '1;
        end
        else
        begin
            energy_cal = quo[CALE_W-1:0];
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_valid_reg)
        begin
            out_reg.status           <= s1_status_reg;
            out_reg.pad_number       <= s1_pad_reg;
            out_reg.sample_number    <= s1_sample_reg;
            out_reg.pad_out_of_range <= s1_oor_reg;
            if (s1_status_reg == ST_HIT)
            begin
                out_reg.cal_energy <= energy_cal;
                out_reg.hit_index  <= s1_hidx_reg;
                out_reg.pad_hits   <= new_cnt;
            end
            else
            begin
                out_reg.cal_energy <= '0;
                out_reg.hit_index  <= '0;
                out_reg.pad_hits   <= '0;
            end
        end
    end

    assign res.valid   = out_valid_reg;
    assign res.payload = out_reg;

`ifndef SYNTHESIS
    // A full, stalled result register blocks new requests while stage one is busy
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_valid_reg && !res.ready |-> !in.ready)
        else $error("request taken while pipeline is stalled");

    // Forwarded counter row only ever accompanies a word in stage one
    a_fwd_with_word: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_valid_reg |-> s1_valid_reg)
        else $error("forward flag set with empty stage one");

    // Dropped words report zero energy and counters
    a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_reg.status != ST_HIT) |->
            (out_reg.cal_energy == '0) && (out_reg.hit_index == '0) &&
            (out_reg.pad_hits == '0))
        else $error("dropped word carries nonzero fields");

    // An accepted hit always counts at least itself on its pad
    a_hit_counted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_reg.status == ST_HIT) |-> (out_reg.pad_hits != '0))
        else $error("accepted hit with zero pad count");

    // Event start leaves the detector's hit count at zero
    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        is_start |=> (hit_count_reg[$past(det)] == '0))
        else $error("hit count not cleared at event start");
`endif

endmodule

`default_nettype wire

// ===== sv/crdc_ram.sv =====
// Generic simple dual-port RAM with registered read data.
`default_nettype none

module crdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== dv/crdc_hit_checker.sv =====
`timescale 1ns / 100ps
// Checker of the pad hit decoder: watches all channels, predicts each result and compares.
module crdc_hit_checker
    import crdc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_ready,
    input  in_item_t  in_item,
    input  logic      res_valid,
    input  logic      res_ready,
    input  res_item_t res_item,
    input  logic      cfg_valid,
    input  logic      cfg_ready,
    input  cfg_req_t  cfg_req,
    output int        fail_count,
    output int        outstanding
);

    localparam int PAD_SLOTS = DETECTORS_DEF * PADS_PER_DETECTOR_DEF;

    // Register copies
    logic [SLIM_W-1:0]   lim_sample;
    logic [HIT_W-1:0]    lim_hits;
    logic [PCNT_W-1:0]   pads_used;

    // Calibration memory, latched word fields and event counters
    logic [PED_W-1:0]    ped_mem   [PAD_SLOTS];
    logic [GAIN_W-1:0]   gain_mem  [PAD_SLOTS];
    logic [HIT_W-1:0]    pad_tally [PAD_SLOTS];
    logic [HIT_W-1:0]    det_hits  [DETECTORS_DEF];
    logic [CHAN_W-1:0]   cur_chan;
    logic [SAMPLE_W-1:0] cur_sample;

    res_item_t expected_hits[$];

    // Subtract pedestal, scale by gain with round half up, clamp at zero and saturate
    function automatic logic [CALE_W-1:0] calibrated_energy(input logic [ENERGY_W-1:0] energy,
                                                            input logic [PED_W-1:0] ped,
                                                            input logic [GAIN_W-1:0] gain);
        logic [PED_W-1:0] scaled;
        logic [31:0]      prod;
        scaled = {energy, {FRAC_W{1'b0}}};
        if (scaled <= ped) begin
            return '0;
        end
        prod = (32'(scaled - ped) * 32'(gain) + 32'(1 << (GAIN_FRAC_W - 1))) >> GAIN_FRAC_W;
        if (prod > 32'hFFFF) begin
            prod = 32'hFFFF;
        end
        return prod[CALE_W-1:0];
    endfunction

    task automatic field_check(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Advance the model by one accepted request
    task automatic predict_hit(input in_item_t it);
        logic [PAD_W:0]    slot;
        logic [PAD_W-1:0]  pad;
        res_item_t         hit;
        case (it.opcode)
            OP_CAL_LOAD:
            begin
                slot = {it.detector, it.cal_pad};
                ped_mem[slot]  = it.cal_pedestal;
                gain_mem[slot] = it.cal_gain;
            end
            OP_EVENT_START:
            begin
                det_hits[it.detector] = '0;
                for (int p = 0; p < PADS_PER_DETECTOR_DEF; p++) begin
                    pad_tally[{it.detector, PAD_W'(p)}] = '0;
                end
            end
            OP_READOUT:
            begin
                if (it.raw_word[CTRL_BIT]) begin
                    cur_chan   = it.raw_word[CHAN_LSB +: CHAN_W];
                    cur_sample = it.raw_word[SAMPLE_LSB +: SAMPLE_W];
                end
                else begin
                    pad  = {it.raw_word[CONN_LSB +: CONN_W], cur_chan};
                    slot = {it.detector, pad};
                    hit  = '0;
                    hit.pad_number       = pad;
                    hit.sample_number    = cur_sample;
                    hit.pad_out_of_range = ({1'b0, pad} >= pads_used);
                    if ({1'b0, cur_sample} >= lim_sample) begin
                        hit.status = ST_SAMPLE_RANGE;
                    end
                    else if (det_hits[it.detector] >= lim_hits) begin
                        hit.status = ST_HIT_LIMIT;
                    end
                    else begin
                        hit.status     = ST_HIT;
                        hit.cal_energy = calibrated_energy(it.raw_word[ENERGY_LSB +: ENERGY_W],
                                                           ped_mem[slot], gain_mem[slot]);
                        hit.hit_index  = det_hits[it.detector];
                        det_hits[it.detector] = det_hits[it.detector] + 1'b1;
                        if (pad_tally[slot] != PAD_HITS_MAX) begin
                            pad_tally[slot] = pad_tally[slot] + 1'b1;
                        end
                        hit.pad_hits = pad_tally[slot];
                    end
                    expected_hits.insert(expected_hits.size(), hit);
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // Take register writes, check results first, then predict the new request
    always @(posedge clk or negedge rst_n) begin
        res_item_t want;
        if (!rst_n) begin
            lim_sample  = SAMPLE_LIMIT_RST;
            lim_hits    = HIT_LIMIT_RST;
            pads_used   = PAD_COUNT_RST;
            cur_chan    = '0;
            cur_sample  = '0;
            for (int d = 0; d < DETECTORS_DEF; d++) begin
                det_hits[d] = '0;
            end
            for (int s = 0; s < PAD_SLOTS; s++) begin
                pad_tally[s] = '0;
            end
            expected_hits.delete();
            fail_count  = 0;
            outstanding = 0;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_req.index)
                    REG_SAMPLE_LIMIT: lim_sample = cfg_req.data[SLIM_W-1:0];
                    REG_HIT_LIMIT:    lim_hits   = cfg_req.data[HIT_W-1:0];
                    REG_PAD_COUNT:    pads_used  = cfg_req.data[PCNT_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (res_valid && res_ready) begin
                if (expected_hits.size() == 0) begin
                    $error("result with no request waiting: pad %0d status %0d",
                           res_item.pad_number, res_item.status);
                    fail_count++;
                end
                else begin
                    want = expected_hits.pop_front();
                    field_check("status", 32'(want.status), 32'(res_item.status));
                    field_check("pad_number", 32'(want.pad_number), 32'(res_item.pad_number));
                    field_check("sample_number", 32'(want.sample_number),
                                32'(res_item.sample_number));
                    field_check("cal_energy", 32'(want.cal_energy), 32'(res_item.cal_energy));
                    field_check("hit_index", 32'(want.hit_index), 32'(res_item.hit_index));
                    field_check("pad_hits", 32'(want.pad_hits), 32'(res_item.pad_hits));
                    field_check("pad_out_of_range", 32'(want.pad_out_of_range),
                                32'(res_item.pad_out_of_range));
                end
            end
            if (in_valid && in_ready) begin
                predict_hit(in_item);
            end
            outstanding = expected_hits.size();
        end
    end

endmodule

// ===== dv/tb_crdc_pad_hit_decoder.sv =====
`timescale 1ns / 100ps
// Testbench top of the pad hit decoder: clock, reset, request traffic, register phases, verdict.
module tb_crdc_pad_hit_decoder;
    import crdc_pkg::*;

    localparam int              WATCHDOG_LIMIT = 4000;
    localparam int              DRAIN_CYCLES   = 4;
    localparam int              PHASE_ITEMS    = 155;
    localparam logic [OPCODE_W-1:0] OP_UNUSED  = 2'd3;

    logic clk = 1'b0;
    logic rst_n;

    crdc_stream_if #(.T(in_item_t))  in_ch  ();
    crdc_stream_if #(.T(res_item_t)) res_ch ();
    crdc_stream_if #(.T(cfg_req_t))  cfg_ch ();

    int                fail_count;
    int                outstanding;
    int                quiet_cycles = 0;
    bit                calm = 1'b0;
    logic              cal_loaded [DETECTORS_DEF * PADS_PER_DETECTOR_DEF];
    logic [CHAN_W-1:0] last_chan;
    int                cur_sample_limit;

    crdc_pad_hit_decoder i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (in_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    crdc_hit_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_ch.valid),
        .in_ready    (in_ch.ready),
        .in_item     (in_ch.payload),
        .res_valid   (res_ch.valid),
        .res_ready   (res_ch.ready),
        .res_item    (res_ch.payload),
        .cfg_valid   (cfg_ch.valid),
        .cfg_ready   (cfg_ch.ready),
        .cfg_req     (cfg_ch.payload),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly short gaps, a few long ones, none in a calm stretch
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) begin
            return 0;
        end
        if (r < 85) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic in_item_t rand_item();
        in_item_t it;
        it.opcode       = OPCODE_W'($urandom_range(0, 3));
        it.detector     = 1'($urandom);
        it.raw_word     = RAW_W'($urandom);
        it.cal_pad      = PAD_W'($urandom);
        it.cal_pedestal = PED_W'($urandom);
        it.cal_gain     = GAIN_W'($urandom);
        return it;
    endfunction

    function automatic in_item_t cal_item(input logic det, input logic [PAD_W-1:0] pad,
                                          input logic [PED_W-1:0] ped,
                                          input logic [GAIN_W-1:0] gain);
        in_item_t it;
        it = rand_item();
        it.opcode       = OP_CAL_LOAD;
        it.detector     = det;
        it.cal_pad      = pad;
        it.cal_pedestal = ped;
        it.cal_gain     = gain;
        return it;
    endfunction

    // Pedestals lean low so that most hits give a nonzero energy
    function automatic logic [PED_W-1:0] rand_ped();
        if ($urandom_range(0, 1) == 0) begin
            return PED_W'($urandom_range(0, 2047));
        end
        return PED_W'($urandom);
    endfunction

    function automatic in_item_t event_item(input logic det);
        in_item_t it;
        it = rand_item();
        it.opcode   = OP_EVENT_START;
        it.detector = det;
        return it;
    endfunction

    function automatic in_item_t ctrl_item(input logic [CHAN_W-1:0] chan,
                                           input logic [SAMPLE_W-1:0] sample);
        in_item_t it;
        it = rand_item();
        it.opcode   = OP_READOUT;
        it.raw_word = {1'b1, sample, chan};
        return it;
    endfunction

    function automatic in_item_t data_item(input logic det, input logic [CONN_W-1:0] conn,
                                           input logic [ENERGY_W-1:0] energy);
        in_item_t it;
        it = rand_item();
        it.opcode   = OP_READOUT;
        it.detector = det;
        it.raw_word = {1'b0, it.raw_word[14:12], conn, energy};
        return it;
    endfunction

    // Offer one request after a random gap and hold it until taken
    task automatic push_request(input in_item_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= it;
        do @(negedge clk); while (!in_ch.ready);
        @(posedge clk);
    endtask

    // Send a request; a data word on a pad never loaded gets its calibration first
    task automatic send_item(input in_item_t it);
        logic [PAD_W:0] slot;
        slot = {it.detector, it.raw_word[CONN_LSB +: CONN_W], last_chan};
        if (it.opcode == OP_READOUT && !it.raw_word[CTRL_BIT] && !cal_loaded[slot]) begin
            cal_loaded[slot] = 1'b1;
            push_request(cal_item(slot[PAD_W], slot[PAD_W-1:0], rand_ped(),
                                  GAIN_W'($urandom)));
        end
        if (it.opcode == OP_CAL_LOAD) begin
            cal_loaded[{it.detector, it.cal_pad}] = 1'b1;
        end
        if (it.opcode == OP_READOUT && it.raw_word[CTRL_BIT]) begin
            last_chan = it.raw_word[CHAN_LSB +: CHAN_W];
        end
        push_request(it);
    endtask

    // Hold off requests until every expected result is out and the pipe is empty
    task automatic drain_pipeline();
        in_ch.valid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input int value);
        cfg_req_t req;
        req.index = idx;
        req.data  = CFG_DATA_W'(value);
        cfg_ch.valid   <= 1'b1;
        cfg_ch.payload <= req;
        do @(negedge clk); while (!cfg_ch.ready);
        @(posedge clk);
    endtask

    task automatic configure(input int slim, input int hlim, input int pads);
        drain_pipeline();
        write_reg(REG_SAMPLE_LIMIT, slim);
        write_reg(REG_HIT_LIMIT, hlim);
        write_reg(REG_PAD_COUNT, pads);
        cfg_ch.valid <= 1'b0;
        cur_sample_limit = slim;
    endtask

    // Mostly bursts (control word, then data words), the rest event starts, loads and noise
    task automatic run_traffic(input int n_items);
        int       sent;
        int       r;
        int       burst;
        int       near;
        bit       paused;
        logic     det;
        in_item_t it;
        sent   = 0;
        paused = 1'b0;
        while (sent < n_items) begin
            if (!paused && sent >= n_items / 2) begin
                drain_pipeline();
                paused = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 8) begin
                send_item(event_item(1'($urandom)));
                sent++;
            end
            else if (r < 16) begin
                send_item(cal_item(1'($urandom), PAD_W'($urandom), rand_ped(),
                                   GAIN_W'($urandom)));
                sent++;
            end
            else if (r < 26) begin
                it = rand_item();
                send_item(it);
                if (it.opcode != OP_UNUSED) begin
                    sent++;
                end
            end
            else begin
                det = 1'($urandom);
                if ($urandom_range(0, 3) == 0) begin
                    near = cur_sample_limit - int'($urandom_range(0, 1));
                    if (near < 0) near = 0;
                    if (near > 511) near = 511;
                end
                else begin
                    near = $urandom_range(0, 511);
                end
                send_item(ctrl_item(CHAN_W'($urandom), SAMPLE_W'(near)));
                sent++;
                burst = $urandom_range(1, 8);
                repeat (burst) begin
                    if ($urandom_range(0, 6) == 0) begin
                        det = ~det;
                    end
                    r = $urandom_range(0, 9);
                    send_item(data_item(det, CONN_W'($urandom),
                                        (r == 0) ? '0 :
                                        (r == 1) ? '1 : ENERGY_W'($urandom)));
                    sent++;
                end
            end
        end
    endtask

    // Flip between calm stretches and stretches with gaps
    initial
    begin
        forever begin
            repeat ($urandom_range(100, 400)) @(negedge clk);
            calm = ($urandom_range(0, 3) == 0);
        end
    end

    // Stall the result side at random
    initial
    begin
        int stall;
        stall = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                stall--;
            end
            else begin
                res_ch.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) begin
                    stall = pick_gap();
                end
            end
        end
    end

    // End the run when nothing moves for too long
    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_crdc_pad_hit_decoder NOT OK");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_ch.valid    <= 1'b0;
        in_ch.payload  <= '0;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.payload <= '0;
        last_chan        = '0;
        cur_sample_limit = SAMPLE_LIMIT_RST;
        for (int s = 0; s < DETECTORS_DEF * PADS_PER_DETECTOR_DEF; s++) begin
            cal_loaded[s] = 1'b0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: calibration extremes, energy extremes, zero clamp, counters, event start
        send_item(cal_item(1'b0, 8'd0, 14'd0, 16'hFFFF));
        send_item(cal_item(1'b0, 8'd255, 14'h3FFF, 16'h0000));
        send_item(cal_item(1'b1, 8'd64, 14'd100, 16'h4000));
        send_item(cal_item(1'b1, 8'd191, 14'h1000, 16'h8000));
        send_item(event_item(1'b0));
        send_item(event_item(1'b1));
        send_item(ctrl_item(6'd0, 9'd0));
        send_item(data_item(1'b0, 2'd0, 10'h3FF));
        send_item(data_item(1'b0, 2'd0, 10'h000));
        send_item(ctrl_item(6'd63, 9'd511));
        send_item(data_item(1'b0, 2'd3, 10'h3FF));
        send_item(ctrl_item(6'd0, 9'd100));
        send_item(data_item(1'b1, 2'd1, 10'd7));
        send_item(data_item(1'b1, 2'd1, 10'd7));
        begin
            in_item_t junk;
            junk = rand_item();
            junk.opcode = OP_UNUSED;
            send_item(junk);
        end
        send_item(event_item(1'b1));
        send_item(data_item(1'b1, 2'd1, 10'd7));
        send_item(data_item(1'b0, 2'd0, 10'd512));
        send_item(ctrl_item(6'd63, 9'd300));
        send_item(data_item(1'b1, 2'd2, 10'h3FF));
        send_item(data_item(1'b0, 2'd3, 10'h000));

        // Random phases over register settings, extremes included
        run_traffic(PHASE_ITEMS);
        configure(0, 4095, 1);
        run_traffic(PHASE_ITEMS);
        configure(512, 0, 256);
        run_traffic(PHASE_ITEMS);
        configure(512, 7, 64);
        run_traffic(PHASE_ITEMS);
        configure($urandom_range(1, 511), $urandom_range(1, 30), $urandom_range(1, 256));
        run_traffic(PHASE_ITEMS);
        configure(1, 4095, 255);
        run_traffic(PHASE_ITEMS);
        configure($urandom_range(0, 512), $urandom_range(0, 4095), $urandom_range(1, 256));
        run_traffic(PHASE_ITEMS);
        configure(512, 4095, 256);
        run_traffic(PHASE_ITEMS);

        drain_pipeline();
        repeat (10) @(posedge clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("tb_crdc_pad_hit_decoder OK");
        end
        else begin
            $display("tb_crdc_pad_hit_decoder NOT OK");
        end
        $finish;
    end

endmodule
